// File: hw/rtl/mhpq_pkg.sv
`default_nettype none

package mhpq_pkg;

	localparam int HEAP_DEPTH  = 64;
	localparam int VALUE_WIDTH = 32;

	localparam logic MODE_INSERT = 1'b0;
	localparam logic MODE_DELETE = 1'b1;

	typedef enum logic [1:0] {
		STATUS_OK    = 2'd0,
		STATUS_FULL  = 2'd1,
		STATUS_EMPTY = 2'd2
	} status_t;

	typedef struct packed {
		logic               mode;
		logic signed [31:0] value;
	} cmd_t;

	typedef struct packed {
		logic signed [31:0] removed_value;
		status_t            status;
		logic [6:0]         count_after;
	} result_t;

endpackage

`default_nettype wire

// File: hw/rtl/mhpq_store.sv
`default_nettype none

module mhpq_store #(
	parameter int HEAP_DEPTH  = mhpq_pkg::HEAP_DEPTH,
	parameter int VALUE_WIDTH = mhpq_pkg::VALUE_WIDTH,
	localparam int AW = $clog2(HEAP_DEPTH)
) (
	input  wire logic                   clk,
	input  wire logic                   we,
	input  wire logic [AW-1:0]          waddr,
	input  wire logic [VALUE_WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]          raddr_a,
	input  wire logic [AW-1:0]          raddr_b,
	output logic      [VALUE_WIDTH-1:0] rdata_a,
	output logic      [VALUE_WIDTH-1:0] rdata_b
);

	logic [VALUE_WIDTH-1:0] mem_q [HEAP_DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

`default_nettype wire

// File: hw/rtl/mhpq_cmp.sv
`default_nettype none

module mhpq_cmp #(
	parameter int VALUE_WIDTH = mhpq_pkg::VALUE_WIDTH
) (
	input  wire logic [VALUE_WIDTH-1:0] a,
	input  wire logic [VALUE_WIDTH-1:0] b,
	output logic                        gt
);

	assign gt = $signed(a) > $signed(b);

endmodule

`default_nettype wire

// File: hw/rtl/mhpq_engine.sv
`default_nettype none

module mhpq_engine #(
	parameter int HEAP_DEPTH  = mhpq_pkg::HEAP_DEPTH,
	parameter int VALUE_WIDTH = mhpq_pkg::VALUE_WIDTH,
	localparam int AW = $clog2(HEAP_DEPTH),
	localparam int CW = $clog2(HEAP_DEPTH + 1),
	localparam int LW = AW + 1
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	output logic                         busy,
	input  wire mhpq_pkg::cmd_t          cmd,
	output logic                         done,
	output mhpq_pkg::result_t            result,
	output logic                         we,
	output logic       [AW-1:0]          waddr,
	output logic       [VALUE_WIDTH-1:0] wdata,
	output logic       [AW-1:0]          raddr_a,
	output logic       [AW-1:0]          raddr_b,
	input  wire logic  [VALUE_WIDTH-1:0] rdata_a,
	input  wire logic  [VALUE_WIDTH-1:0] rdata_b,
	output logic       [VALUE_WIDTH-1:0] cmp_a,
	output logic       [VALUE_WIDTH-1:0] cmp_b,
	input  wire logic                    gt
);

	typedef enum logic [6:0] {
		ST_IDLE    = 7'b0000001,
		ST_UP_RD   = 7'b0000010,
		ST_UP_CMP  = 7'b0000100,
		ST_DN_LOAD = 7'b0001000,
		ST_DN_RD   = 7'b0010000,
		ST_DN_CMP1 = 7'b0100000,
		ST_DN_CMP2 = 7'b1000000
	} state_t;

	state_t                  state_q, state_d;
	logic [CW-1:0]           count_q, count_d;
	logic [AW-1:0]           pos_q, pos_d;
	logic [AW-1:0]           pick_q, pick_d;
	logic [VALUE_WIDTH-1:0]  v_q, v_d;
	logic [VALUE_WIDTH-1:0]  cv_q, cv_d;
	logic [VALUE_WIDTH-1:0]  removed_q, removed_d;
	mhpq_pkg::status_t       status_q, status_d;
	logic                    done_q, done_d;
	logic                    fin;
	logic [LW-1:0]           l_idx, r_idx, n_ext;
	logic [AW-1:0]           parent;

	assign busy  = state_q != ST_IDLE;
	assign l_idx = {pos_q, 1'b1};
	assign r_idx = l_idx + LW'(1);
	assign n_ext = LW'(count_q);
	assign parent = AW'((pos_q - AW'(1)) >> 1);

	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		pos_d     = pos_q;
		pick_d    = pick_q;
		v_d       = v_q;
		cv_d      = cv_q;
		removed_d = removed_q;
		status_d  = status_q;
		done_d    = 1'b0;
		fin       = 1'b0;
		we        = 1'b0;
		waddr     = pos_q;
		wdata     = v_q;
		raddr_a   = '0;
		raddr_b   = AW'(count_q - CW'(1));
		cmp_a     = v_q;
		cmp_b     = rdata_a;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					removed_d = '0;
					if (cmd.mode == mhpq_pkg::MODE_INSERT) begin
						if (count_q == CW'(HEAP_DEPTH)) begin
							done_d   = 1'b1;
							status_d = mhpq_pkg::STATUS_FULL;
						end else begin
							pos_d   = AW'(count_q);
							v_d     = VALUE_WIDTH'($signed(cmd.value));
							count_d = count_q + CW'(1);
							state_d = ST_UP_RD;
						end
					end else begin
						if (count_q == '0) begin
							done_d   = 1'b1;
							status_d = mhpq_pkg::STATUS_EMPTY;
						end else begin
							count_d = count_q - CW'(1);
							state_d = ST_DN_LOAD;
						end
					end
				end
			end
			ST_UP_RD: begin
				raddr_a = parent;
				if (pos_q == '0) begin
					we  = 1'b1;
					fin = 1'b1;
				end else begin
					state_d = ST_UP_CMP;
				end
			end
			ST_UP_CMP: begin
				we = 1'b1;
				if (gt) begin
					wdata   = rdata_a;
					pos_d   = parent;
					state_d = ST_UP_RD;
				end else begin
					fin = 1'b1;
				end
			end
			ST_DN_LOAD: begin
				removed_d = rdata_a;
				v_d       = rdata_b;
				pos_d     = '0;
				if (count_q == '0) begin
					fin = 1'b1;
				end else begin
					state_d = ST_DN_RD;
				end
			end
			ST_DN_RD: begin
				raddr_a = l_idx[AW-1:0];
				raddr_b = r_idx[AW-1:0];
				if (l_idx >= n_ext) begin
					we  = 1'b1;
					fin = 1'b1;
				end else begin
					state_d = ST_DN_CMP1;
				end
			end
			ST_DN_CMP1: begin
				cmp_a = rdata_b;
				cmp_b = rdata_a;
				if (r_idx < n_ext && gt) begin
					pick_d = r_idx[AW-1:0];
					cv_d   = rdata_b;
				end else begin
					pick_d = l_idx[AW-1:0];
					cv_d   = rdata_a;
				end
				state_d = ST_DN_CMP2;
			end
			ST_DN_CMP2: begin
				cmp_a = cv_q;
				cmp_b = v_q;
				we    = 1'b1;
				if (gt) begin
					wdata   = cv_q;
					pos_d   = pick_q;
					state_d = ST_DN_RD;
				end else begin
					fin = 1'b1;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		if (fin) begin
			done_d   = 1'b1;
			status_d = mhpq_pkg::STATUS_OK;
			state_d  = ST_IDLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			done_q  <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		pos_q     <= pos_d;
		pick_q    <= pick_d;
		v_q       <= v_d;
		cv_q      <= cv_d;
		removed_q <= removed_d;
		status_q  <= status_d;
	end

	assign done                 = done_q;
	assign result.removed_value = 32'(removed_q);
	assign result.status        = status_q;
	assign result.count_after   = 7'(count_q);

endmodule

`default_nettype wire

// File: hw/rtl/max_heap_priority_queue_top.sv
// Binary max-heap priority queue. Raise start with a command word while busy is low: an insert
// adds a signed value, a delete removes the maximum. Exactly one result word follows, shown for
// a single cycle with done high; it cannot be held off, so sample it then. A full insert or an
// empty delete is refused at once (the result follows in the next cycle, heap untouched). An
// insert climbs a level at a time: it reads the parent, then moves it down while the new value
// compares greater, and writes the value where it stops or at the root. A delete returns the
// root and sifts the last value down from it: it reads both children, picks the larger, then
// moves that child up while it compares greater than the value, until the value settles in a
// node without children or above both; a delete of the only element just removes it. Each level
// costs one registered read of the single heap memory and one pass through the shared
// comparator on an insert, two on a delete. busy drops as the result appears.
`default_nettype none

module max_heap_priority_queue_top #(
	parameter int HEAP_DEPTH  = mhpq_pkg::HEAP_DEPTH,
	parameter int VALUE_WIDTH = mhpq_pkg::VALUE_WIDTH
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire mhpq_pkg::cmd_t    cmd,
	output logic                   done,
	output mhpq_pkg::result_t      result
);

	localparam int AW = $clog2(HEAP_DEPTH);

	logic                   we;
	logic [AW-1:0]          waddr, raddr_a, raddr_b;
	logic [VALUE_WIDTH-1:0] wdata, rdata_a, rdata_b, cmp_a, cmp_b;
	logic                   gt;

	mhpq_engine #(
		.HEAP_DEPTH  (HEAP_DEPTH),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_engine (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.cmd     (cmd),
		.done    (done),
		.result  (result),
		.we      (we),
		.waddr   (waddr),
		.wdata   (wdata),
		.raddr_a (raddr_a),
		.raddr_b (raddr_b),
		.rdata_a (rdata_a),
		.rdata_b (rdata_b),
		.cmp_a   (cmp_a),
		.cmp_b   (cmp_b),
		.gt      (gt)
	);

	mhpq_store #(
		.HEAP_DEPTH  (HEAP_DEPTH),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_store (
		.clk     (clk),
		.we      (we),
		.waddr   (waddr),
		.wdata   (wdata),
		.raddr_a (raddr_a),
		.raddr_b (raddr_b),
		.rdata_a (rdata_a),
		.rdata_b (rdata_b)
	);

	mhpq_cmp #(
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_cmp (
		.a  (cmp_a),
		.b  (cmp_b),
		.gt (gt)
	);

endmodule

`default_nettype wire
